FILE: design/vectored_interrupt_controller_assert.svh
// Assertion macros for the interrupt controller
`ifndef VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH
// Implication checked on every clock, disabled while in reset
`define VIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define VIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg
// Types and constants of the vectored interrupt controller.
// ----------------------------------------------------------------------------
package vic_pkg;
	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_MARK  = 3'd2;
	localparam logic [2:0] OP_SERVE = 3'd3;
	localparam logic [2:0] OP_RET   = 3'd4;

	localparam logic CFG_CPU_ID = 1'b0;
	localparam logic CFG_VBASE  = 1'b1;

	localparam logic [31:0] RESET_CTRL_KEY = 32'hFA050000;
	localparam logic [31:0] VTOR_MASK      = 32'hFFFFFF80;
	localparam logic [31:0] CCR_RESET      = 32'h00000200;
	localparam logic [31:0] ICTR_VALUE     = 32'h0000001F;
	localparam logic [31:0] LOW_HALF       = 32'h0000FFFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] addr;
		logic [31:0] wdata;
		logic [8:0]  exc_number;
		logic        pend_value;
		logic        primask;
	} vic_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        taken;
		logic [7:0]  taken_exception;
		logic [31:0] vector_address;
	} vic_out_t;

	typedef struct packed {
		logic       start;
		logic       prep;
		logic       scan_step;
		logic       finish;
	} vic_cmd_t;

	typedef struct packed {
		logic       scan_last;
		logic       is_serve;
	} vic_sts_t;
endpackage

FILE: design/vic_if.sv
// ----------------------------------------------------------------------------
// vic_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface vic_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/vic_cfg_if.sv
// ----------------------------------------------------------------------------
// vic_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface vic_cfg_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: design/vic_ctrl.sv
// ----------------------------------------------------------------------------
// vic_ctrl
// Sequencer: accept, read ahead, scan candidates and flush (unmasked service requests only), commit, output result.
// ----------------------------------------------------------------------------
module vic_ctrl import vic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  vic_sts_t sts,
	output vic_cmd_t cmd
);
	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_SCAN, ST_FLUSH, ST_DONE, ST_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.start     = in_valid && state_q == ST_IDLE;
		cmd.prep      = state_q == ST_PREP;
		cmd.scan_step = state_q == ST_SCAN;
		cmd.finish    = state_q == ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_PREP;
				ST_PREP:  state_q <= sts.is_serve ? ST_SCAN : ST_DONE;
				ST_SCAN:  if (sts.scan_last) state_q <= ST_FLUSH;
				ST_FLUSH: state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_OUT;
				ST_OUT:   if (out_ready) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`include "vectored_interrupt_controller_assert.svh"
	`VIC_ASSERT_IMP(a_excl, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`VIC_ASSERT_NXT(a_start, clk, arst_n, cmd.start, state_q == ST_PREP)
	`VIC_ASSERT_NXT(a_done, clk, arst_n, cmd.finish, out_valid)
endmodule

FILE: design/vic_dp.sv
// ----------------------------------------------------------------------------
// vic_dp
// Register file, candidate scan and commit logic. Interrupt priority bytes
// sit in a word memory with one registered read a cycle; a valid bit per
// word makes a word that was never written read as zero.
// ----------------------------------------------------------------------------
module vic_dp import vic_pkg::*; #(
	parameter int SCANNED_IRQS     = 82,
	parameter int PRIORITY_ENTRIES = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  vic_cmd_t    cmd,
	output vic_sts_t    sts,
	input  vic_in_t     in_item,
	input  logic [31:0] cpu_id,
	input  logic [31:0] vbase,
	output vic_out_t    res
);
	localparam int NSCAN = 3 + SCANNED_IRQS;
	localparam int CW    = $clog2(NSCAN + 1);
	localparam int NPW   = (PRIORITY_ENTRIES + 3) / 4;
	localparam int PW    = (NPW > 1) ? $clog2(NPW) : 1;

	logic [31:0] en_q [8];
	logic [31:0] pend_q [8];
	logic [31:0] act_q [8];
	logic [7:0]  sprio_q [12];
	logic [31:0] vtor_q, aircr_q, scr_q, ccr_q, cpacr_q;
	logic [8:0]  cur_q;
	logic        nmi_q, pendsv_q, systick_q;

	vic_in_t     it_q;
	logic [CW-1:0] idx_q;
	logic [8:0]  best_q;
	logic [9:0]  bestp_q;
	vic_out_t    res_q;
	assign res = res_q;

	logic [11:0] a;
	assign a = {it_q.addr[11:2], 2'b00};

	assign sts.is_serve  = it_q.op == OP_SERVE && !it_q.primask;
	assign sts.scan_last = idx_q == CW'(NSCAN - 1);

	logic [11:0] po;
	logic [3:0]  so;
	assign po = a - 12'h400;
	assign so = 4'(a - 12'hD18);

	logic [8:0] ci;
	assign ci = cur_q - 9'd16;

	// scan element
	logic [8:0] se;
	logic [7:0] sirq;
	logic       sok;
	logic [9:0] ssp;
	always_comb begin
		case (idx_q)
			CW'(0):  se = 9'd2;
			CW'(1):  se = 9'd14;
			CW'(2):  se = 9'd15;
			default: se = 9'(idx_q) + 9'd13;
		endcase
		sirq = 8'(se - 9'd16);
		if (se == 9'd2) sok = nmi_q;
		else if (se == 9'd14) sok = pendsv_q;
		else if (se == 9'd15) sok = systick_q;
		else sok = pend_q[sirq[7:5]][sirq[4:0]] && en_q[sirq[7:5]][sirq[4:0]];
		if (se == 9'd2) ssp = 10'h3FD;
		else if (se < 9'd16) ssp = {2'b00, sprio_q[4'(se - 9'd4)]};
		else ssp = 10'd0;
	end

	// priority word memory
	logic [31:0]    pmem [NPW];
	logic [NPW-1:0] pvld_q;
	logic [31:0]    pword_s1;
	logic           pvld_s1;
	logic [1:0]     pbs_s1;
	logic [PW-1:0]  pra, pwa;
	logic [1:0]     pbs;
	logic           pwe;
	logic [7:0]     pbyte;

	always_comb begin
		if (cmd.scan_step) begin
			pra = PW'(sirq[7:2]); pbs = sirq[1:0];
		end else if (it_q.op == OP_READ) begin
			pra = PW'(po[7:2]); pbs = 2'd0;
		end else begin
			pra = PW'(ci[7:2]); pbs = ci[1:0];
		end
	end

	assign pwa = PW'(po[7:2]);
	assign pwe = cmd.finish && it_q.op == OP_WRITE && a >= 12'h400 && a < 12'h4F0 &&
		32'(po[7:2]) < NPW;
	assign pbyte = pvld_s1 ? pword_s1[8*pbs_s1 +: 8] : 8'd0;

	always_ff @(posedge clk) begin
		if (pwe) pmem[pwa] <= it_q.wdata;
		pword_s1 <= pmem[pra];
	end

	// compare stage
	logic       v_s1, sok_s1, sin_s1, prep_s1;
	logic [8:0] se_s1;
	logic [9:0] ssp_s1, sp;
	logic [7:0] curb_q;
	always_comb begin
		if (se_s1 < 9'd16) sp = ssp_s1;
		else if (sin_s1) sp = {2'b00, pbyte};
		else sp = 10'd0;
	end

	// read mux
	logic [31:0] rd;
	logic [31:0] prd;
	always_comb begin
		for (int k = 0; k < 4; k++)
			prd[8*k +: 8] = (pvld_s1 && 32'(po) + k < PRIORITY_ENTRIES) ?
				pword_s1[8*k +: 8] : 8'd0;
		rd = '0;
		if (a == 12'h000) rd = ICTR_VALUE;
		else if (a == 12'hD00) rd = cpu_id;
		else if (a == 12'hD04) rd = {nmi_q, 2'b0, pendsv_q, 1'b0, systick_q, 17'd0, cur_q};
		else if (a == 12'hD08) rd = vtor_q;
		else if (a == 12'hD0C) rd = aircr_q;
		else if (a == 12'hD10) rd = scr_q;
		else if (a == 12'hD14) rd = ccr_q;
		else if (a == 12'hD88) rd = cpacr_q;
		else if (a >= 12'hD18 && a < 12'hD24)
			rd = {sprio_q[so+4'd3], sprio_q[so+4'd2], sprio_q[so+4'd1], sprio_q[so]};
		else if (a >= 12'h100 && a < 12'h120) rd = en_q[a[4:2]];
		else if (a >= 12'h180 && a < 12'h1A0) rd = en_q[a[4:2]];
		else if (a >= 12'h200 && a < 12'h220) rd = pend_q[a[4:2]];
		else if (a >= 12'h280 && a < 12'h2A0) rd = pend_q[a[4:2]];
		else if (a >= 12'h300 && a < 12'h320) rd = act_q[a[4:2]];
		else if (a >= 12'h400 && a < 12'h4F0) rd = prd;
	end

	logic [9:0] curp;
	logic       go;
	always_comb begin
		if (cur_q < 9'd4) curp = 10'h3FD;
		else if (cur_q < 9'd16) curp = {2'b00, sprio_q[4'(cur_q - 9'd4)]};
		else if (32'(ci) < PRIORITY_ENTRIES) curp = {2'b00, curb_q};
		else curp = 10'd0;
	end
	assign go = best_q != 9'd0 &&
		(cur_q == 9'd0 || $signed(bestp_q) < $signed(curp));

	logic [8:0] bi, di, di_m;
	assign bi   = best_q - 9'd16;
	assign di   = cur_q - 9'd16;
	assign di_m = it_q.exc_number - 9'd16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				en_q[i] <= '0; pend_q[i] <= '0; act_q[i] <= '0;
			end
			for (int i = 0; i < 12; i++) sprio_q[i] <= '0;
			vtor_q <= '0; aircr_q <= RESET_CTRL_KEY; scr_q <= '0;
			ccr_q <= CCR_RESET; cpacr_q <= '0; cur_q <= '0;
			nmi_q <= 1'b0; pendsv_q <= 1'b0; systick_q <= 1'b0;
			idx_q <= '0; best_q <= '0; bestp_q <= '0;
			res_q <= '0; pvld_q <= '0; pvld_s1 <= 1'b0; pbs_s1 <= '0;
			v_s1 <= 1'b0; sok_s1 <= 1'b0; sin_s1 <= 1'b0; prep_s1 <= 1'b0;
			se_s1 <= '0; ssp_s1 <= '0; curb_q <= '0;
		end else begin
			pvld_s1 <= pvld_q[pra];
			pbs_s1  <= pbs;
			prep_s1 <= cmd.prep;
			v_s1    <= cmd.scan_step;
			if (prep_s1) curb_q <= pbyte;
			if (cmd.start) begin
				idx_q <= '0; best_q <= '0; bestp_q <= 10'd256;
			end
			if (cmd.scan_step) begin
				if (!sts.scan_last) idx_q <= idx_q + CW'(1);
				se_s1 <= se; sok_s1 <= sok; ssp_s1 <= ssp;
				sin_s1 <= 32'(sirq) < PRIORITY_ENTRIES;
			end
			if (v_s1 && sok_s1 && $signed(sp) < $signed(bestp_q)) begin
				best_q <= se_s1; bestp_q <= sp;
			end
			if (cmd.finish) begin
				res_q <= '0;
				case (it_q.op)
					OP_READ: res_q.read_data <= rd;
					OP_WRITE: begin
						if (a == 12'hD04) begin
							if (it_q.wdata[26]) systick_q <= 1'b1;
							else if (it_q.wdata[25]) systick_q <= 1'b0;
							if (it_q.wdata[28]) pendsv_q <= 1'b1;
							else if (it_q.wdata[27]) pendsv_q <= 1'b0;
							if (it_q.wdata[31]) nmi_q <= 1'b1;
						end else if (a == 12'hD08) vtor_q <= it_q.wdata & VTOR_MASK;
						else if (a == 12'hD0C)
							aircr_q <= (it_q.wdata & LOW_HALF) | RESET_CTRL_KEY;
						else if (a == 12'hD10) scr_q <= it_q.wdata;
						else if (a == 12'hD14) ccr_q <= it_q.wdata;
						else if (a == 12'hD88) cpacr_q <= it_q.wdata;
						else if (a >= 12'hD18 && a < 12'hD24) begin
							for (int k = 0; k < 4; k++)
								if (32'(so) + k < 12)
									sprio_q[32'(so) + k] <= it_q.wdata[8*k +: 8];
						end else if (a >= 12'h100 && a < 12'h120)
							en_q[a[4:2]] <= en_q[a[4:2]] | it_q.wdata;
						else if (a >= 12'h180 && a < 12'h1A0)
							en_q[a[4:2]] <= en_q[a[4:2]] & ~it_q.wdata;
						else if (a >= 12'h200 && a < 12'h220)
							pend_q[a[4:2]] <= pend_q[a[4:2]] | it_q.wdata;
						else if (a >= 12'h280 && a < 12'h2A0)
							pend_q[a[4:2]] <= pend_q[a[4:2]] & ~it_q.wdata;
						else if (a >= 12'h400 && a < 12'h4F0) begin
							if (pwe) pvld_q[pwa] <= 1'b1;
						end
					end
					OP_MARK: begin
						if (it_q.exc_number == 9'd2) nmi_q <= it_q.pend_value;
						else if (it_q.exc_number == 9'd14) pendsv_q <= it_q.pend_value;
						else if (it_q.exc_number == 9'd15) systick_q <= it_q.pend_value;
						else if (it_q.exc_number >= 9'd16 && it_q.exc_number < 9'd256)
							pend_q[di_m[7:5]][di_m[4:0]] <= it_q.pend_value;
					end
					OP_SERVE: if (sts.is_serve && go) begin
						cur_q <= best_q;
						if (best_q == 9'd2) nmi_q <= 1'b0;
						else if (best_q == 9'd14) pendsv_q <= 1'b0;
						else if (best_q == 9'd15) systick_q <= 1'b0;
						else begin
							pend_q[bi[7:5]][bi[4:0]] <= 1'b0;
							act_q[bi[7:5]][bi[4:0]] <= 1'b1;
						end
						res_q.taken <= 1'b1;
						res_q.taken_exception <= best_q[7:0];
						res_q.vector_address <= ((vtor_q != 32'd0) ? vtor_q : vbase) +
							{21'd0, best_q, 2'b00};
					end
					OP_RET: begin
						if (cur_q >= 9'd16 && cur_q < 9'd272)
							act_q[di[7:5]][di[4:0]] <= 1'b0;
						cur_q <= it_q.exc_number;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) it_q <= in_item;
	end

	`include "vectored_interrupt_controller_assert.svh"
	`VIC_ASSERT_NXT(a_tk, clk, arst_n, cmd.finish, !res_q.taken || it_q.op == OP_SERVE)
	`VIC_ASSERT_NXT(a_cur, clk, arst_n, cmd.finish && go && sts.is_serve, cur_q != 9'd0)
	`VIC_ASSERT_IMP(a_idx, clk, arst_n, 1'b1, 32'(idx_q) < NSCAN)
endmodule

FILE: design/vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_controller
// Interrupt controller register page with priority arbitration.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   op, addr, wdata, exc_number, pend_value, primask
// out_ch    out  read_data, taken, taken_exception, vector_address
// cfg       in   index (cpu_id, vector_base_default), wdata
// Service request: after accept, read-ahead, one scan cycle per candidate, flush,
// commit, then the result is valid. Other ops and masked requests skip scan and flush.
// One item at a time; a stalled result holds until taken and blocks the input.
// Reset is asynchronous but spares the captured request and the priority memory;
// priority words read zero until written.
module vectored_interrupt_controller import vic_pkg::*; #(
	parameter int SCANNED_IRQS     = 82,
	parameter int PRIORITY_ENTRIES = 240
) (
	input logic  clk,
	input logic  arst_n,
	vic_if.sink  in_ch,
	vic_if.source out_ch,
	vic_cfg_if.sink cfg
);
	vic_cmd_t cmd;
	vic_sts_t sts;
	logic [31:0] cpu_id_q, vbase_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_id_q <= '0; vbase_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_CPU_ID) cpu_id_q <= cfg.wdata;
			else vbase_q <= cfg.wdata;
		end
	end

	vic_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	vic_dp #(.SCANNED_IRQS(SCANNED_IRQS), .PRIORITY_ENTRIES(PRIORITY_ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_item(in_ch.data), .cpu_id(cpu_id_q), .vbase(vbase_q), .res(out_ch.data)
	);
endmodule
